// ----- rtl/cdls_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdls_pkg
// Types, codes and the reset key decode shared by the deletion length stack.
// ----------------------------------------------------------------------------
package cdls_pkg;

    localparam int ENTRY_W = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 8;

    typedef logic [ENTRY_W-1:0] entry_t;

    typedef enum logic [2:0] {
        MODE_START   = 3'd0,
        MODE_END     = 3'd1,
        MODE_KEY     = 3'd2,
        MODE_UNKNOWN = 3'd3,
        MODE_POP     = 3'd4,
        MODE_CLEAR   = 3'd5
    } mode_t;

    localparam logic [CFG_ADDR_W-1:0] CFG_UNKNOWN_ENABLE    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_COLLAPSE_UNKNOWNS = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_BACKSPACE_CODE    = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_RESET_MOD_MASK    = 2'd3;

    localparam entry_t ENTRY_UNKNOWN = 16'hFFFF;
    localparam entry_t COUNT_MAX     = 16'h7FFF;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_POP,
        CELL_CLEAR,
        CELL_DEC
    } cell_op_t;

    typedef struct packed {
        cell_op_t front_op;
        cell_op_t rest_op;
        entry_t   push_value;
        entry_t   popped_value;
    } stack_cmd_t;

    // navigation, escape, tab, locks, print screen, delete, F1..F12
    function automatic logic is_reset_key(input logic [7:0] key);
        logic hit;
        hit = 1'b0;
        case (key)
            8'h52, 8'h51, 8'h50, 8'h4F, 8'h4A, 8'h4D, 8'h4B, 8'h4E, 8'h29,
            8'h2B, 8'h39, 8'h46, 8'h47, 8'h4C, 8'h53,
            8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F,
            8'h40, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

// ----- rtl/cdls_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdls_cell
// One stack entry; loads from its front or back neighbor on push and pop, clears or counts down.
// ----------------------------------------------------------------------------
module cdls_cell
    import cdls_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  cell_op_t op,
    input  entry_t   from_front,
    input  entry_t   from_back,
    output entry_t   value,
    output entry_t   value_next
);

    entry_t value_reg;

    always_comb begin
        case (op)
            CELL_HOLD:  value_next = value_reg;
            CELL_PUSH:  value_next = from_front;
            CELL_POP:   value_next = from_back;
            CELL_CLEAR: value_next = '0;
            CELL_DEC:   value_next = value_reg - entry_t'(1);
            default:    value_next = value_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg <= '0;
        end else begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

// ----- rtl/cdls_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdls_ctrl
// Event decode, group counter and configuration registers; drives the cells.
// ----------------------------------------------------------------------------
module cdls_ctrl
    import cdls_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  logic [2:0]            mode,
    input  logic [7:0]            usage_code,
    input  logic [7:0]            modifier_bits,
    input  entry_t                front,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    output stack_cmd_t            cmd
);

    logic       unknown_enable_reg;
    logic       collapse_unknowns_reg;
    logic [7:0] backspace_code_reg;
    logic [7:0] reset_mod_mask_reg;
    entry_t     group_count_reg;
    entry_t     group_count_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unknown_enable_reg    <= 1'b1;
            collapse_unknowns_reg <= 1'b0;
            backspace_code_reg    <= 8'd42;
            reset_mod_mask_reg    <= 8'd13;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_UNKNOWN_ENABLE:    unknown_enable_reg    <= cfg_wr_data[0];
                CFG_COLLAPSE_UNKNOWNS: collapse_unknowns_reg <= cfg_wr_data[0];
                CFG_BACKSPACE_CODE:    backspace_code_reg    <= cfg_wr_data;
                CFG_RESET_MOD_MASK:    reset_mod_mask_reg    <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        group_count_next  = group_count_reg;
        cmd.front_op      = CELL_HOLD;
        cmd.rest_op       = CELL_HOLD;
        cmd.push_value    = group_count_reg;
        cmd.popped_value  = '0;
        if (accept) begin
            case (mode)
                MODE_START: begin
                    group_count_next = '0;
                end
                MODE_END: begin
                    if (group_count_reg != '0) begin
                        cmd.front_op = CELL_PUSH;
                        cmd.rest_op  = CELL_PUSH;
                    end
                end
                MODE_KEY: begin
                    if (usage_code == backspace_code_reg) begin
                        if (front != '0 && !front[ENTRY_W-1]) begin
                            if (front == entry_t'(1)) begin
                                cmd.front_op = CELL_POP;
                                cmd.rest_op  = CELL_POP;
                            end else begin
                                cmd.front_op = CELL_DEC;
                            end
                        end
                    end else if (is_reset_key(usage_code) ||
                                 (modifier_bits & reset_mod_mask_reg) != 8'd0) begin
                        group_count_next = '0;
                        cmd.front_op     = CELL_CLEAR;
                        cmd.rest_op      = CELL_CLEAR;
                    end else if (usage_code != 8'd0 && group_count_reg != COUNT_MAX) begin
                        group_count_next = group_count_reg + entry_t'(1);
                    end
                end
                MODE_UNKNOWN: begin
                    if (unknown_enable_reg &&
                        !(collapse_unknowns_reg && front == ENTRY_UNKNOWN)) begin
                        group_count_next = ENTRY_UNKNOWN;
                    end
                end
                MODE_POP: begin
                    cmd.front_op     = CELL_POP;
                    cmd.rest_op      = CELL_POP;
                    cmd.popped_value = front;
                end
                MODE_CLEAR: begin
                    cmd.front_op = CELL_CLEAR;
                    cmd.rest_op  = CELL_CLEAR;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_count_reg <= '0;
        end else begin
            group_count_reg <= group_count_next;
        end
    end

endmodule

// ----- rtl/chord_deletion_length_stack_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chord_deletion_length_stack_top
// Shift stack of per-group character counts for chord deletion.
// ----------------------------------------------------------------------------
// Usage:
//   Event requests enter on s_* (valid/ready): mode, key code, modifier byte.
//   Each request yields exactly one result on m_* (valid/ready): the value a
//   pop removed, the front entry after the event, and an unknown flag.
//   m_valid rises in the cycle after acceptance. One request per cycle is
//   taken unless the result stalls; the stack is a row of STACK_DEPTH cells
//   that all shift in the same cycle, and the group counter updates in it too.
//   The result sits in an output register; s_ready is high while that
//   register is empty or being read, so a stalled receiver holds at most one
//   result and back-pressures the input after it.
//   Reset (aresetn low, synchronous) clears every entry, the group count and
//   m_valid, and loads the configuration defaults. The configuration port
//   (cfg_wr_en, cfg_index, cfg_wr_data) writes with no read-back. The user
//   must use it only while no result is pending; the block does not enforce it.
// ----------------------------------------------------------------------------
module chord_deletion_length_stack_top
    import cdls_pkg::*;
#(
    parameter int STACK_DEPTH = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [2:0]            s_mode,
    input  logic [7:0]            s_usage_code,
    input  logic [7:0]            s_modifier_bits,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [15:0]    m_popped_value,
    output logic signed [15:0]    m_front_value,
    output logic                  m_front_unknown,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    logic       accept;
    stack_cmd_t cmd;
    entry_t     entry [STACK_DEPTH];
    entry_t     entry_next [STACK_DEPTH];

    logic              m_valid_reg;
    logic              m_valid_next;
    logic signed [15:0] m_popped_value_reg;
    logic signed [15:0] m_front_value_reg;
    logic              m_front_unknown_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    cdls_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .mode          (s_mode),
        .usage_code    (s_usage_code),
        .modifier_bits (s_modifier_bits),
        .front         (entry[0]),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .cmd           (cmd)
    );

    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
        entry_t from_front;
        entry_t from_back;
        if (i == 0) begin : g_first
            assign from_front = cmd.push_value;
        end else begin : g_mid_front
            assign from_front = entry[i-1];
        end
        if (i == STACK_DEPTH - 1) begin : g_last
            assign from_back = '0;
        end else begin : g_mid_back
            assign from_back = entry[i+1];
        end
        cdls_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .op         ((i == 0) ? cmd.front_op : cmd.rest_op),
            .from_front (from_front),
            .from_back  (from_back),
            .value      (entry[i]),
            .value_next (entry_next[i])
        );
    end

    always_comb begin
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_popped_value_reg  <= cmd.popped_value;
            m_front_value_reg   <= entry_next[0];
            m_front_unknown_reg <= (entry_next[0] == ENTRY_UNKNOWN);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_popped_value  = m_popped_value_reg;
    assign m_front_value   = m_front_value_reg;
    assign m_front_unknown = m_front_unknown_reg;

    // result register reflects the front cell right after the request
    a_front_tracks_cell: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (m_front_value_reg == entry[0]))
        else $error("front result does not match front cell");

    a_unknown_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (m_front_unknown_reg == (m_front_value_reg == ENTRY_UNKNOWN)))
        else $error("unknown flag inconsistent with front value");

    a_pop_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_mode != MODE_POP) |=> (m_popped_value_reg == 16'sd0))
        else $error("popped value set by a non-pop request");

    a_no_accept_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !accept)
        else $error("request accepted while result is stalled");

endmodule

// ----- bench/chord_deletion_length_stack_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chord_deletion_length_stack_top_test
// Self-checking bench for the chord deletion length stack. A directed table
// walks the corner events: pop on empty, unknown groups, backspace, reset by
// modifier, clear and a spare mode. Random group sequences mixed with
// noise follow under several register settings. Every request is predicted
// in the bench and each result is checked field by field.
// Both channels see random gaps and stalls.
// ----------------------------------------------------------------------------
module chord_deletion_length_stack_top_test
    import cdls_pkg::*;
;

    localparam int STACK_DEPTH   = 8;
    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 5;
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_ITEMS   = 95;
    localparam int RAND_PHASES   = 6;
    localparam int DRAIN_CYCLES  = 4;

    localparam logic [2:0] MODE_SPARE_6 = 3'd6;
    localparam logic [2:0] MODE_SPARE_7 = 3'd7;

    localparam logic [7:0] KEY_NONE      = 8'h00;
    localparam logic [7:0] KEY_A         = 8'h04;
    localparam logic [7:0] KEY_ERASE     = 8'h2A;
    localparam logic [7:0] KEY_MAX       = 8'hFF;
    localparam logic [7:0] MOD_NONE      = 8'h00;
    localparam logic [7:0] MOD_LSHIFT    = 8'h02;
    localparam logic [7:0] MOD_LGUI      = 8'h08;
    localparam logic [7:0] MOD_ALL       = 8'hFF;
    localparam logic [7:0] MASK_DEFAULT  = 8'h0D;

    localparam logic [7:0] CLEARING_KEYS [27] = '{
        8'h52, 8'h51, 8'h50, 8'h4F, 8'h4A, 8'h4D, 8'h4B, 8'h4E, 8'h29,
        8'h2B, 8'h39, 8'h46, 8'h47, 8'h4C, 8'h53,
        8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F,
        8'h40, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45
    };

    typedef struct packed {
        logic signed [15:0] popped;
        logic signed [15:0] front;
        logic               unknown;
    } stack_result_t;

    typedef enum logic {
        ROW_EVENT,
        ROW_CONFIG
    } row_kind_t;

    // config rows: key holds the register index, mods the value
    typedef struct packed {
        row_kind_t          kind;
        logic [2:0]         mode;
        logic [7:0]         key;
        logic [7:0]         mods;
        logic               known;
        logic signed [15:0] popped;
        logic signed [15:0] front;
        logic               unknown;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 30;
    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{ROW_EVENT, MODE_POP,     KEY_NONE,      MOD_NONE,   1'b1, 16'sd0,  16'sd0,  1'b0},
        '{ROW_EVENT, MODE_START,   KEY_NONE,      MOD_NONE,   1'b1, 16'sd0,  16'sd0,  1'b0},
        '{ROW_EVENT, MODE_KEY,     KEY_A,         MOD_NONE,   1'b0, 16'sd0,  16'sd0,  1'b0},
        '{ROW_EVENT, MODE_KEY,     KEY_NONE,      MOD_LSHIFT, 1'b0, 16'sd0,  16'sd0,  1'b0},
        '{ROW_EVENT, MODE_KEY,     KEY_MAX,       MOD_LSHIFT, 1'b0, 16'sd0,  16'sd0,  1'b0},
        '{ROW_EVENT, MODE_END,     KEY_NONE,      MOD_NONE,   1'b1, 16'sd0,  16'sd2,  1'b0},
        '{ROW_EVENT, MODE_START,   KEY_NONE,      MOD_NONE,   1'b0, 16'sd0,  16'sd0,  1'b0},
        '{ROW_EVENT, MODE_UNKNOWN, KEY_NONE,      MOD_NONE,   1'b0, 16'sd0,  16'sd0,  1'b0},
        '{ROW_EVENT, MODE_END,     KEY_NONE,      MOD_NONE,   1'b1, 16'sd0,  -16'sd1, 1'b1},
        '{ROW_EVENT, MODE_KEY,     KEY_ERASE,     MOD_NONE,   1'b1, 16'sd0,  -16'sd1, 1'b1},
        '{ROW_EVENT, MODE_POP,     KEY_NONE,      MOD_NONE,   1'b1, -16'sd1, 16'sd2,  1'b0},
        '{ROW_EVENT, MODE_KEY,     KEY_ERASE,     MOD_ALL,    1'b1, 16'sd0,  16'sd1,  1'b0},
        '{ROW_EVENT, MODE_KEY,     KEY_ERASE,     MOD_NONE,   1'b1, 16'sd0,  16'sd0,  1'b0},
        '{ROW_EVENT, MODE_KEY,     KEY_ERASE,     MOD_NONE,   1'b1, 16'sd0,  16'sd0,  1'b0},
        '{ROW_EVENT, MODE_START,   KEY_NONE,      MOD_NONE,   1'b0, 16'sd0,  16'sd0,  1'b0},
        '{ROW_EVENT, MODE_UNKNOWN, KEY_NONE,      MOD_NONE,   1'b0, 16'sd0,  16'sd0,  1'b0},
        '{ROW_EVENT, MODE_KEY,     KEY_A,         MOD_NONE,   1'b0, 16'sd0,  16'sd0,  1'b0},
        '{ROW_EVENT, MODE_KEY,     KEY_A,         MOD_NONE,   1'b0, 16'sd0,  16'sd0,  1'b0},
        '{ROW_EVENT, MODE_END,     KEY_NONE,      MOD_NONE,   1'b1, 16'sd0,  16'sd1,  1'b0},
        '{ROW_EVENT, MODE_CLEAR,   KEY_NONE,      MOD_NONE,   1'b1, 16'sd0,  16'sd0,  1'b0},
        '{ROW_EVENT, MODE_END,     KEY_NONE,      MOD_NONE,   1'b1, 16'sd0,  16'sd1,  1'b0},
        '{ROW_EVENT, MODE_SPARE_7, KEY_MAX,       MOD_ALL,    1'b1, 16'sd0,  16'sd1,  1'b0},
        '{ROW_EVENT, MODE_KEY,     KEY_A,         MOD_LGUI,   1'b1, 16'sd0,  16'sd0,  1'b0},
        '{ROW_CONFIG, MODE_START, {6'd0, CFG_COLLAPSE_UNKNOWNS}, 8'h01,
          1'b0, 16'sd0, 16'sd0, 1'b0},
        '{ROW_EVENT, MODE_START,   KEY_NONE,      MOD_NONE,   1'b0, 16'sd0,  16'sd0,  1'b0},
        '{ROW_EVENT, MODE_UNKNOWN, KEY_NONE,      MOD_NONE,   1'b0, 16'sd0,  16'sd0,  1'b0},
        '{ROW_EVENT, MODE_END,     KEY_NONE,      MOD_NONE,   1'b1, 16'sd0,  -16'sd1, 1'b1},
        '{ROW_EVENT, MODE_START,   KEY_NONE,      MOD_NONE,   1'b0, 16'sd0,  16'sd0,  1'b0},
        '{ROW_EVENT, MODE_UNKNOWN, KEY_NONE,      MOD_NONE,   1'b0, 16'sd0,  16'sd0,  1'b0},
        '{ROW_EVENT, MODE_END,     KEY_NONE,      MOD_NONE,   1'b1, 16'sd0,  -16'sd1, 1'b1}
    };

    logic                  aclk            = 1'b0;
    logic                  aresetn         = 1'b0;
    logic                  s_valid         = 1'b0;
    logic                  s_ready;
    logic [2:0]            s_mode          = MODE_START;
    logic [7:0]            s_usage_code    = KEY_NONE;
    logic [7:0]            s_modifier_bits = MOD_NONE;
    logic                  m_valid;
    logic                  m_ready         = 1'b0;
    logic signed [15:0]    m_popped_value;
    logic signed [15:0]    m_front_value;
    logic                  m_front_unknown;
    logic                  cfg_wr_en       = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_index       = CFG_UNKNOWN_ENABLE;
    logic [CFG_DATA_W-1:0] cfg_wr_data     = '0;

    // bench copy of the block state and registers
    entry_t     len_stack [STACK_DEPTH];
    entry_t     grp_count;
    logic       cfg_unknown_en;
    logic       cfg_collapse;
    logic [7:0] cfg_bs_code;
    logic [7:0] cfg_reset_mask;

    stack_result_t result_q [$];
    int            fail_count     = 0;
    int            accepted_items = 0;
    int            idle_cycles    = 0;
    int            ready_left     = 0;
    bit            no_idle        = 1'b0;

    chord_deletion_length_stack_top #(
        .STACK_DEPTH(STACK_DEPTH)
    ) DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_usage_code   (s_usage_code),
        .s_modifier_bits(s_modifier_bits),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_popped_value (m_popped_value),
        .m_front_value  (m_front_value),
        .m_front_unknown(m_front_unknown),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data)
    );

    always #CLK_HALF aclk = ~aclk;

    function automatic void drop_front();
        int i;
        for (i = 0; i < STACK_DEPTH - 1; i++)
            len_stack[i] = len_stack[i + 1];
        len_stack[STACK_DEPTH - 1] = '0;
    endfunction

    function automatic void clear_lengths();
        int i;
        for (i = 0; i < STACK_DEPTH; i++)
            len_stack[i] = '0;
    endfunction

    function automatic stack_result_t apply_event(input logic [2:0] mode,
                                                  input logic [7:0] key,
                                                  input logic [7:0] mods);
        stack_result_t res;
        logic          clear_hit;
        int            i;
        res.popped = '0;
        case (mode)
            MODE_START: grp_count = '0;
            MODE_END: begin
                if (grp_count != '0) begin
                    for (i = STACK_DEPTH - 1; i > 0; i--)
                        len_stack[i] = len_stack[i - 1];
                    len_stack[0] = grp_count;
                end
            end
            MODE_KEY: begin
                clear_hit = (mods & cfg_reset_mask) != '0;
                for (i = 0; i < 27; i++)
                    if (key == CLEARING_KEYS[i])
                        clear_hit = 1'b1;
                if (key == cfg_bs_code) begin
                    // only a positive front entry counts down
                    if (len_stack[0] != '0 && !len_stack[0][ENTRY_W-1]) begin
                        len_stack[0] = len_stack[0] - 1'b1;
                        if (len_stack[0] == '0)
                            drop_front();
                    end
                end else if (clear_hit) begin
                    grp_count = '0;
                    clear_lengths();
                end else if (key != KEY_NONE && grp_count != COUNT_MAX) begin
                    grp_count = grp_count + 1'b1;
                end
            end
            MODE_UNKNOWN: begin
                if (cfg_unknown_en && !(cfg_collapse && len_stack[0] == ENTRY_UNKNOWN))
                    grp_count = ENTRY_UNKNOWN;
            end
            MODE_POP: begin
                res.popped = len_stack[0];
                drop_front();
            end
            MODE_CLEAR: clear_lengths();
            default: ;
        endcase
        res.front   = len_stack[0];
        res.unknown = (len_stack[0] == ENTRY_UNKNOWN);
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] rand_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 68)
            return 8'($urandom_range(4, 56));
        if (r < 83)
            return cfg_bs_code;
        if (r < 87)
            return CLEARING_KEYS[$urandom_range(0, 26)];
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] rand_mods();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return MOD_NONE;
        if (r < 92)
            return 8'($urandom_range(0, 255)) & ~cfg_reset_mask;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic stop_input();
        s_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (result_q.size() != 0)
            @(posedge aclk);
    endtask

    // one request; the expectation is queued at the accepting edge
    task automatic send_event(input logic [2:0]    mode,
                              input logic [7:0]    key,
                              input logic [7:0]    mods,
                              input bit            use_typed = 1'b0,
                              input stack_result_t typed_res = '0);
        int            gap;
        stack_result_t res;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_mode          <= mode;
        s_usage_code    <= key;
        s_modifier_bits <= mods;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        res = apply_event(mode, key, mods);
        result_q.push_back(use_typed ? typed_res : res);
        if (mode <= MODE_CLEAR)
            accepted_items++;
    endtask

    // leaves cfg_wr_en high; the caller lowers it
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [7:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        case (idx)
            CFG_UNKNOWN_ENABLE:    cfg_unknown_en = data[0];
            CFG_COLLAPSE_UNKNOWNS: cfg_collapse   = data[0];
            CFG_BACKSPACE_CODE:    cfg_bs_code    = data;
            CFG_RESET_MOD_MASK:    cfg_reset_mask = data;
            default: ;
        endcase
    endtask

    task automatic write_config(input logic ue, input logic cu,
                                input logic [7:0] bs, input logic [7:0] mask);
        write_reg(CFG_UNKNOWN_ENABLE, {7'd0, ue});
        write_reg(CFG_COLLAPSE_UNKNOWNS, {7'd0, cu});
        write_reg(CFG_BACKSPACE_CODE, bs);
        write_reg(CFG_RESET_MOD_MASK, mask);
        cfg_wr_en <= 1'b0;
    endtask

    // mostly well-formed groups with random content, some noise
    task automatic send_random_burst();
        int r;
        int n;
        r       = $urandom_range(0, 99);
        no_idle = ($urandom_range(0, 7) == 0);
        if (r < 20) begin
            repeat ($urandom_range(1, 4))
                send_event(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)));
        end else begin
            send_event(MODE_START, rand_key(), rand_mods());
            n = $urandom_range(0, 6);
            repeat (n) begin
                if ($urandom_range(0, 9) == 0)
                    send_event(MODE_UNKNOWN, rand_key(), rand_mods());
                else
                    send_event(MODE_KEY, rand_key(), rand_mods());
            end
            if ($urandom_range(0, 9) != 0)
                send_event(MODE_END, rand_key(), rand_mods());
            repeat ($urandom_range(0, 3))
                send_event(MODE_KEY, cfg_bs_code, rand_mods());
            if ($urandom_range(0, 7) == 0)
                send_event(MODE_POP, rand_key(), rand_mods());
            if ($urandom_range(0, 19) == 0)
                send_event(MODE_CLEAR, rand_key(), rand_mods());
        end
    endtask

    always @(posedge aclk) begin
        if (no_idle) begin
            m_ready <= 1'b1;
        end else if (ready_left == 0) begin
            m_ready    <= ($urandom_range(0, 3) != 0);
            ready_left = pick_gap();
        end else begin
            ready_left--;
        end
    end

    always @(posedge aclk) begin : result_check
        stack_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (result_q.size() == 0) begin
                $error("result with no request pending: front_value %0d", m_front_value);
                fail_count++;
            end else begin
                want = result_q.pop_front();
                if (m_popped_value !== want.popped) begin
                    $error("popped_value: expected %0d, got %0d", want.popped, m_popped_value);
                    fail_count++;
                end
                if (m_front_value !== want.front) begin
                    $error("front_value: expected %0d, got %0d", want.front, m_front_value);
                    fail_count++;
                end
                if (m_front_unknown !== want.unknown) begin
                    $error("front_unknown: expected %0d, got %0d",
                           want.unknown, m_front_unknown);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en || !aresetn)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        directed_row_t row;
        stack_result_t typed;
        int            r;
        int            ph;
        int            phase_start;

        clear_lengths();
        grp_count      = '0;
        cfg_unknown_en = 1'b1;
        cfg_collapse   = 1'b0;
        cfg_bs_code    = KEY_ERASE;
        cfg_reset_mask = MASK_DEFAULT;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (r = 0; r < DIRECTED_ROWS; r++) begin
            row = DIRECTED[r];
            if (row.kind == ROW_CONFIG) begin
                stop_input();
                wait_drained();
                write_reg(row.key[CFG_ADDR_W-1:0], row.mods);
            end else begin
                cfg_wr_en <= 1'b0;
                typed     = '{row.popped, row.front, row.unknown};
                send_event(row.mode, row.key, row.mods, row.known, typed);
            end
        end
        cfg_wr_en <= 1'b0;

        for (ph = 0; ph < RAND_PHASES; ph++) begin
            stop_input();
            wait_drained();
            case (ph)
                0: write_config(1'b1, 1'b0, KEY_ERASE, MASK_DEFAULT);
                1: write_config(1'b0, 1'b0, 8'h00, 8'h00);
                2: write_config(1'b1, 1'b1, 8'hFF, 8'hFF);
                3: write_config(1'b1, 1'b1, 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255)));
                default: write_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                      8'($urandom_range(0, 255)),
                                      8'($urandom_range(0, 255)));
            endcase
            phase_start = accepted_items;
            while (accepted_items - phase_start < PHASE_ITEMS) begin
                send_random_burst();
                if ($urandom_range(0, 49) == 0) begin
                    // hold requests until every result is back
                    stop_input();
                    wait_drained();
                end
            end
        end

        stop_input();
        no_idle = 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (result_q.size() != 0) begin
            $error("%0d results never arrived", result_q.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
